// ----- rtl/scc_pkg.sv -----
// Shared types, codes and constants for the subtitle cue checker.
package scc_pkg;

    localparam int CMD_W   = 2;
    localparam int MS_W    = 32;
    localparam int BYTE_W  = 8;
    localparam int FLAGS_W = 10;
    localparam int OUT_W   = 16;
    localparam int IDX_W   = 3;
    localparam int DATA_W  = 32;
    localparam int VDIM_W  = 13;
    localparam int LIM_REG_W = 16;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int TIME_WIDTH_DEF  = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_BEGIN = 2'd0,
        CMD_TEXT  = 2'd1,
        CMD_END   = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    typedef enum logic [IDX_W-1:0] {
        REG_VIDEO_WIDTH    = 3'd0,
        REG_VIDEO_HEIGHT   = 3'd1,
        REG_SD_LINE_LIMIT  = 3'd2,
        REG_HD_LINE_LIMIT  = 3'd3,
        REG_MIN_DURATION   = 3'd4,
        REG_MAX_DURATION   = 3'd5,
        REG_MAX_LINES      = 3'd6,
        REG_MAX_TEXT_BYTES = 3'd7
    } cfg_reg_t;

    // Closing tag matcher: "<", "</", "</s", "</sp", "</spa", "</span", "</" + i/b/u
    typedef enum logic [2:0] {
        TAG_IDLE   = 3'd0,
        TAG_LT     = 3'd1,
        TAG_SLASH  = 3'd2,
        TAG_S      = 3'd3,
        TAG_SP     = 3'd4,
        TAG_SPA    = 3'd5,
        TAG_SPAN   = 3'd6,
        TAG_LETTER = 3'd7
    } tag_state_t;

    localparam int FLAG_OVERLAP   = 0;
    localparam int FLAG_ORDER     = 1;
    localparam int FLAG_SHORT     = 2;
    localparam int FLAG_LONG      = 3;
    localparam int FLAG_LINE_LONG = 4;
    localparam int FLAG_LINES     = 5;
    localparam int FLAG_CONTROL   = 6;
    localparam int FLAG_EMPTY     = 7;
    localparam int FLAG_VERBOSE   = 8;
    localparam int FLAG_TAGS      = 9;

    typedef struct packed {
        logic [FLAGS_W-1:0] flags;
        logic [OUT_W-1:0]   longest_line;
        logic [OUT_W-1:0]   line_count;
        logic [OUT_W-1:0]   error_count;
    } result_t;

    localparam logic [VDIM_W-1:0]    HD_WIDTH_MIN  = 13'd720;
    localparam logic [VDIM_W-1:0]    HD_HEIGHT_MIN = 13'd576;

    localparam logic [VDIM_W-1:0]    RST_VIDEO_WIDTH    = 13'd0;
    localparam logic [VDIM_W-1:0]    RST_VIDEO_HEIGHT   = 13'd0;
    localparam logic [LIM_REG_W-1:0] RST_SD_LINE_LIMIT  = 16'd37;
    localparam logic [LIM_REG_W-1:0] RST_HD_LINE_LIMIT  = 16'd67;
    localparam logic [MS_W-1:0]      RST_MIN_DURATION   = 32'd250;
    localparam logic [MS_W-1:0]      RST_MAX_DURATION   = 32'd10000;
    localparam logic [LIM_REG_W-1:0] RST_MAX_LINES      = 16'd3;
    localparam logic [LIM_REG_W-1:0] RST_MAX_TEXT_BYTES = 16'd200;

    localparam logic [BYTE_W-1:0] UTF_MASK1  = 8'h80;
    localparam logic [BYTE_W-1:0] UTF_MASK2  = 8'hE0;
    localparam logic [BYTE_W-1:0] UTF_LEAD2  = 8'hC0;
    localparam logic [BYTE_W-1:0] UTF_MASK3  = 8'hF0;
    localparam logic [BYTE_W-1:0] UTF_LEAD3  = 8'hE0;
    localparam logic [BYTE_W-1:0] UTF_MASK4  = 8'hF8;
    localparam logic [BYTE_W-1:0] UTF_LEAD4  = 8'hF0;
    localparam logic [BYTE_W-1:0] CTRL_LIMIT = 8'h20;

    localparam logic [BYTE_W-1:0] CHAR_NL    = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CHAR_LT    = 8'h3C;
    localparam logic [BYTE_W-1:0] CHAR_GT    = 8'h3E;
    localparam logic [BYTE_W-1:0] CHAR_SLASH = 8'h2F;
    localparam logic [BYTE_W-1:0] CHAR_S     = 8'h73;
    localparam logic [BYTE_W-1:0] CHAR_P     = 8'h70;
    localparam logic [BYTE_W-1:0] CHAR_A     = 8'h61;
    localparam logic [BYTE_W-1:0] CHAR_N     = 8'h6E;
    localparam logic [BYTE_W-1:0] CHAR_I     = 8'h69;
    localparam logic [BYTE_W-1:0] CHAR_B     = 8'h62;
    localparam logic [BYTE_W-1:0] CHAR_U     = 8'h75;

endpackage

// ----- rtl/scc_cue_if.sv -----
// Input request channel: begin, text byte, end and clear commands.
interface scc_cue_if;
    logic                        valid;
    logic                        ready;
    logic [scc_pkg::CMD_W-1:0]   command;
    logic [scc_pkg::MS_W-1:0]    begin_ms;
    logic [scc_pkg::MS_W-1:0]    end_ms;
    logic [scc_pkg::BYTE_W-1:0]  text_byte;

    modport source (output valid, command, begin_ms, end_ms, text_byte, input ready);
    modport sink   (input valid, command, begin_ms, end_ms, text_byte, output ready);
endinterface

// ----- rtl/scc_result_if.sv -----
// Result request channel: flag word and counts for each finished cue.
interface scc_result_if;
    logic                        valid;
    logic                        ready;
    logic [scc_pkg::FLAGS_W-1:0] flags;
    logic [scc_pkg::OUT_W-1:0]   longest_line;
    logic [scc_pkg::OUT_W-1:0]   line_count;
    logic [scc_pkg::OUT_W-1:0]   error_count;

    modport source (output valid, flags, longest_line, line_count, error_count, input ready);
    modport sink   (input valid, flags, longest_line, line_count, error_count, output ready);
endinterface

// ----- rtl/scc_cfg_if.sv -----
// Configuration write channel: register index and write data.
interface scc_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [scc_pkg::IDX_W-1:0]   index;
    logic [scc_pkg::DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/subtitle_cue_checker.sv -----
// Top level of the subtitle cue checker: cue state, checks and result buffer.
//
//  channel  dir  payload                                           accepted when
//  cue      in   command, begin_ms, end_ms, text_byte              cue.valid & cue.ready
//  result   out  flags, longest_line, line_count, error_count      result.valid & result.ready
//  cfg      in   index, data                                       cfg.valid & cfg.ready
//
// One request a cycle on cue: each request updates the cue state in the cycle it is
// accepted; the result of an end request is on result from the next cycle on, unless
// older results still wait there.
// The output register plus one skid entry let cue keep moving while a result waits;
// cue.ready drops only while the skid entry is full.
// cfg is always ready. Reset (rst_n low, asynchronous) restores register defaults,
// clears all cue state and empties the result buffer. No clearing pass is needed.
module subtitle_cue_checker #(
    parameter int COUNT_WIDTH = scc_pkg::COUNT_WIDTH_DEF,
    parameter int TIME_WIDTH  = scc_pkg::TIME_WIDTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    scc_cue_if.sink        cue,
    scc_result_if.source   result,
    scc_cfg_if.sink        cfg
);

    // Compare widths: wide enough for both the state and the configured limit.
    localparam int CMP_W = (TIME_WIDTH > scc_pkg::MS_W) ? TIME_WIDTH : scc_pkg::MS_W;
    localparam int LIM_W = (COUNT_WIDTH > scc_pkg::LIM_REG_W) ? COUNT_WIDTH
                                                               : scc_pkg::LIM_REG_W;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [scc_pkg::VDIM_W-1:0]    video_width_reg;
    logic [scc_pkg::VDIM_W-1:0]    video_height_reg;
    logic [scc_pkg::LIM_REG_W-1:0] sd_line_limit_reg;
    logic [scc_pkg::LIM_REG_W-1:0] hd_line_limit_reg;
    logic [scc_pkg::MS_W-1:0]      min_duration_reg;
    logic [scc_pkg::MS_W-1:0]      max_duration_reg;
    logic [scc_pkg::LIM_REG_W-1:0] max_lines_reg;
    logic [scc_pkg::LIM_REG_W-1:0] max_text_bytes_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            video_width_reg    <= scc_pkg::RST_VIDEO_WIDTH;
            video_height_reg   <= scc_pkg::RST_VIDEO_HEIGHT;
            sd_line_limit_reg  <= scc_pkg::RST_SD_LINE_LIMIT;
            hd_line_limit_reg  <= scc_pkg::RST_HD_LINE_LIMIT;
            min_duration_reg   <= scc_pkg::RST_MIN_DURATION;
            max_duration_reg   <= scc_pkg::RST_MAX_DURATION;
            max_lines_reg      <= scc_pkg::RST_MAX_LINES;
            max_text_bytes_reg <= scc_pkg::RST_MAX_TEXT_BYTES;
        end
        else if (cfg.valid)
        begin
            unique case (scc_pkg::cfg_reg_t'(cfg.index))
                scc_pkg::REG_VIDEO_WIDTH:
                    video_width_reg    <= cfg.data[scc_pkg::VDIM_W-1:0];
                scc_pkg::REG_VIDEO_HEIGHT:
                    video_height_reg   <= cfg.data[scc_pkg::VDIM_W-1:0];
                scc_pkg::REG_SD_LINE_LIMIT:
                    sd_line_limit_reg  <= cfg.data[scc_pkg::LIM_REG_W-1:0];
                scc_pkg::REG_HD_LINE_LIMIT:
                    hd_line_limit_reg  <= cfg.data[scc_pkg::LIM_REG_W-1:0];
                scc_pkg::REG_MIN_DURATION:
                    min_duration_reg   <= cfg.data[scc_pkg::MS_W-1:0];
                scc_pkg::REG_MAX_DURATION:
                    max_duration_reg   <= cfg.data[scc_pkg::MS_W-1:0];
                scc_pkg::REG_MAX_LINES:
                    max_lines_reg      <= cfg.data[scc_pkg::LIM_REG_W-1:0];
                scc_pkg::REG_MAX_TEXT_BYTES:
                    max_text_bytes_reg <= cfg.data[scc_pkg::LIM_REG_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Cue state
    // ------------------------------------------------------------------
    logic [TIME_WIDTH-1:0]  prev_end_reg,   prev_end_next;
    logic                   prev_valid_reg, prev_valid_next;
    logic [COUNT_WIDTH-1:0] errors_reg,     errors_next;
    logic [TIME_WIDTH-1:0]  cue_start_reg,  cue_start_next;
    logic [TIME_WIDTH-1:0]  cue_end_reg,    cue_end_next;
    logic [COUNT_WIDTH-1:0] line_len_reg,   line_len_next;
    logic [COUNT_WIDTH-1:0] max_len_reg,    max_len_next;
    logic [COUNT_WIDTH-1:0] lines_reg,      lines_next;
    logic [COUNT_WIDTH-1:0] bytes_reg,      bytes_next;
    logic [1:0]             skip_reg,       skip_next;
    logic                   ended_nl_reg,   ended_nl_next;
    logic                   control_reg,    control_next;
    logic                   tag_seen_reg,   tag_seen_next;
    scc_pkg::tag_state_t    tag_reg,        tag_next;

    scc_pkg::cmd_t          cmd;
    logic                   cue_accept;
    logic                   produce;
    logic [scc_pkg::BYTE_W-1:0] b;
    scc_pkg::result_t       res;

    // Result buffer: output register and one skid entry.
    scc_pkg::result_t       out_reg,  out_next;
    logic                   out_valid_reg, out_valid_next;
    scc_pkg::result_t       skid_reg, skid_next;
    logic                   skid_valid_reg, skid_valid_next;
    logic                   out_take;

    assign cmd        = scc_pkg::cmd_t'(cue.command);
    assign b          = cue.text_byte;
    assign cue.ready  = !skid_valid_reg;
    assign cue_accept = cue.valid && cue.ready;
    assign produce    = cue_accept && (cmd == scc_pkg::CMD_END);

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
        return (v == COUNT_MAX) ? v : v + COUNT_WIDTH'(1);
    endfunction

    // Closing-tag matcher: next state for the incoming byte.
    logic tag_hit;
    always_comb
    begin
        tag_next = scc_pkg::TAG_IDLE;
        tag_hit  = 1'b0;
        unique case (tag_reg)
            scc_pkg::TAG_IDLE: ;
            scc_pkg::TAG_LT:
                if (b == scc_pkg::CHAR_SLASH) tag_next = scc_pkg::TAG_SLASH;
            scc_pkg::TAG_SLASH:
            begin
                if (b == scc_pkg::CHAR_S)
                    tag_next = scc_pkg::TAG_S;
                else if (b == scc_pkg::CHAR_I || b == scc_pkg::CHAR_B || b == scc_pkg::CHAR_U)
                    tag_next = scc_pkg::TAG_LETTER;
            end
            scc_pkg::TAG_S:
                if (b == scc_pkg::CHAR_P) tag_next = scc_pkg::TAG_SP;
            scc_pkg::TAG_SP:
                if (b == scc_pkg::CHAR_A) tag_next = scc_pkg::TAG_SPA;
            scc_pkg::TAG_SPA:
                if (b == scc_pkg::CHAR_N) tag_next = scc_pkg::TAG_SPAN;
            scc_pkg::TAG_SPAN, scc_pkg::TAG_LETTER:
                tag_hit = (b == scc_pkg::CHAR_GT);
            default: ;
        endcase
        // A '<' restarts the match whenever the current one fails.
        if (tag_next == scc_pkg::TAG_IDLE && b == scc_pkg::CHAR_LT)
            tag_next = scc_pkg::TAG_LT;
        // Hold the matcher unless a text byte arrives; begin and end reset it.
        if (!(cue_accept && cmd == scc_pkg::CMD_TEXT))
            tag_next = tag_reg;
        if (cue_accept && (cmd == scc_pkg::CMD_BEGIN || cmd == scc_pkg::CMD_END))
            tag_next = scc_pkg::TAG_IDLE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tag_reg <= scc_pkg::TAG_IDLE;
        else
            tag_reg <= tag_next;
    end

    // End-of-cue checks, evaluated on the current state.
    logic [TIME_WIDTH-1:0]  dur;
    logic                   backwards;
    logic [COUNT_WIDTH-1:0] longest;
    logic [COUNT_WIDTH-1:0] errors_inc;
    logic                   hd;
    logic [scc_pkg::LIM_REG_W-1:0] line_limit;

    always_comb
    begin
        dur        = cue_end_reg - cue_start_reg;
        backwards  = cue_end_reg < cue_start_reg;
        longest    = (line_len_reg > max_len_reg) ? line_len_reg : max_len_reg;
        errors_inc = (cue_end_reg <= cue_start_reg) ? sat_inc(errors_reg) : errors_reg;
        hd         = (video_width_reg > scc_pkg::HD_WIDTH_MIN)
                  || (video_height_reg > scc_pkg::HD_HEIGHT_MIN);
        line_limit = hd ? hd_line_limit_reg : sd_line_limit_reg;

        res.flags = '0;
        res.flags[scc_pkg::FLAG_OVERLAP]   = prev_valid_reg && (cue_start_reg < prev_end_reg);
        res.flags[scc_pkg::FLAG_ORDER]     = cue_end_reg <= cue_start_reg;
        res.flags[scc_pkg::FLAG_SHORT]     = backwards
                                          || (CMP_W'(dur) < CMP_W'(min_duration_reg));
        res.flags[scc_pkg::FLAG_LONG]      = !backwards
                                          && (CMP_W'(dur) > CMP_W'(max_duration_reg));
        res.flags[scc_pkg::FLAG_LINE_LONG] = LIM_W'(longest) > LIM_W'(line_limit);
        res.flags[scc_pkg::FLAG_LINES]     = LIM_W'(lines_reg) > LIM_W'(max_lines_reg);
        res.flags[scc_pkg::FLAG_CONTROL]   = control_reg;
        res.flags[scc_pkg::FLAG_EMPTY]     = bytes_reg == '0;
        res.flags[scc_pkg::FLAG_VERBOSE]   = LIM_W'(bytes_reg) > LIM_W'(max_text_bytes_reg);
        res.flags[scc_pkg::FLAG_TAGS]      = tag_seen_reg;
        res.longest_line = scc_pkg::OUT_W'(longest);
        res.line_count   = scc_pkg::OUT_W'(lines_reg);
        res.error_count  = scc_pkg::OUT_W'(errors_inc);
    end

    // Next cue state for the accepted request.
    always_comb
    begin
        prev_end_next   = prev_end_reg;
        prev_valid_next = prev_valid_reg;
        errors_next     = errors_reg;
        cue_start_next  = cue_start_reg;
        cue_end_next    = cue_end_reg;
        line_len_next   = line_len_reg;
        max_len_next    = max_len_reg;
        lines_next      = lines_reg;
        bytes_next      = bytes_reg;
        skip_next       = skip_reg;
        ended_nl_next   = ended_nl_reg;
        control_next    = control_reg;
        tag_seen_next   = tag_seen_reg;

        if (cue_accept)
        begin
            unique case (cmd)
                scc_pkg::CMD_BEGIN:
                begin
                    cue_start_next = TIME_WIDTH'(cue.begin_ms);
                    cue_end_next   = TIME_WIDTH'(cue.end_ms);
                end
                scc_pkg::CMD_TEXT:
                begin
                    bytes_next = sat_inc(bytes_reg);
                    if (b < scc_pkg::CTRL_LIMIT && b != scc_pkg::CHAR_NL
                        && b != scc_pkg::CHAR_TAB)
                        control_next = 1'b1;
                    if (tag_hit)
                        tag_seen_next = 1'b1;
                    // A pending newline becomes a line once another byte follows.
                    if (ended_nl_reg)
                    begin
                        lines_next    = sat_inc(lines_reg);
                        ended_nl_next = 1'b0;
                    end
                    if (skip_reg != 2'd0)
                        skip_next = skip_reg - 2'd1;
                    else if (b == scc_pkg::CHAR_NL)
                    begin
                        if (line_len_reg > max_len_reg)
                            max_len_next = line_len_reg;
                        line_len_next = '0;
                        ended_nl_next = 1'b1;
                    end
                    else
                    begin
                        priority if ((b & scc_pkg::UTF_MASK1) == 8'h00)
                            skip_next = 2'd0;
                        else if ((b & scc_pkg::UTF_MASK2) == scc_pkg::UTF_LEAD2)
                            skip_next = 2'd1;
                        else if ((b & scc_pkg::UTF_MASK3) == scc_pkg::UTF_LEAD3)
                            skip_next = 2'd2;
                        else if ((b & scc_pkg::UTF_MASK4) == scc_pkg::UTF_LEAD4)
                            skip_next = 2'd3;
                        else
                            skip_next = 2'd0;
                        line_len_next = sat_inc(line_len_reg);
                    end
                end
                scc_pkg::CMD_END:
                begin
                    errors_next     = errors_inc;
                    prev_end_next   = cue_end_reg;
                    prev_valid_next = 1'b1;
                end
                scc_pkg::CMD_CLEAR:
                    errors_next = '0;
                default: ;
            endcase

            // Begin and end drop all text state; end keeps the cue times.
            if (cmd == scc_pkg::CMD_BEGIN || cmd == scc_pkg::CMD_END)
            begin
                line_len_next = '0;
                max_len_next  = '0;
                lines_next    = COUNT_WIDTH'(1);
                bytes_next    = '0;
                skip_next     = 2'd0;
                ended_nl_next = 1'b0;
                control_next  = 1'b0;
                tag_seen_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_end_reg   <= '0;
            prev_valid_reg <= 1'b0;
            errors_reg     <= '0;
            cue_start_reg  <= '0;
            cue_end_reg    <= '0;
            line_len_reg   <= '0;
            max_len_reg    <= '0;
            lines_reg      <= COUNT_WIDTH'(1);
            bytes_reg      <= '0;
            skip_reg       <= 2'd0;
            ended_nl_reg   <= 1'b0;
            control_reg    <= 1'b0;
            tag_seen_reg   <= 1'b0;
        end
        else
        begin
            prev_end_reg   <= prev_end_next;
            prev_valid_reg <= prev_valid_next;
            errors_reg     <= errors_next;
            cue_start_reg  <= cue_start_next;
            cue_end_reg    <= cue_end_next;
            line_len_reg   <= line_len_next;
            max_len_reg    <= max_len_next;
            lines_reg      <= lines_next;
            bytes_reg      <= bytes_next;
            skip_reg       <= skip_next;
            ended_nl_reg   <= ended_nl_next;
            control_reg    <= control_next;
            tag_seen_reg   <= tag_seen_next;
        end
    end

    // ------------------------------------------------------------------
    // Result buffer: advance skid into the output register as it drains.
    // ------------------------------------------------------------------
    assign out_take = out_valid_reg && result.ready;

    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || out_take)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_next       = res;
                skid_valid_next = produce;
            end
            else
            begin
                out_next       = res;
                out_valid_next = produce;
            end
        end
        else if (produce)
        begin
            skid_next       = res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign result.valid        = out_valid_reg;
    assign result.flags        = out_reg.flags;
    assign result.longest_line = out_reg.longest_line;
    assign result.line_count   = out_reg.line_count;
    assign result.error_count  = out_reg.error_count;

`ifndef SYNTH
    // The skid entry fills only behind a waiting output.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid without output register");

    // After an accepted end request, result.valid is high in the next cycle.
    a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        produce |=> result.valid)
        else $error("end request lost");

    // A pending newline means the current line is still empty.
    a_newline_clears_line: assert property (@(posedge clk) disable iff (!rst_n)
        ended_nl_reg |-> (line_len_reg == '0))
        else $error("line length not cleared after newline");
`endif

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for subtitle_cue_checker: directed cues, counter growth, random streams.
module tb;

    localparam int HALF_PERIOD     = 6;
    localparam int RESET_CYCLES    = 6;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int RANDOM_REQUESTS = 1000;
    localparam int RANDOM_BLOCKS   = 8;
    localparam int SETTLE_CYCLES   = 4;
    localparam int REPORT_LIMIT    = 40;
    localparam int GROWTH_RUN      = 48;

    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
    typedef enum {SET_ZERO, SET_FULL, SET_MIXED} setting_kind_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    scc_cue_if    cue_bus ();
    scc_result_if report_bus ();
    scc_cfg_if    cfg_bus ();

    subtitle_cue_checker dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cue    (cue_bus),
        .result (report_bus),
        .cfg    (cfg_bus)
    );

    always #HALF_PERIOD clk = ~clk;

    // Register copies, starting from the reset values.
    logic [scc_pkg::VDIM_W-1:0]    video_width_set   = scc_pkg::RST_VIDEO_WIDTH;
    logic [scc_pkg::VDIM_W-1:0]    video_height_set  = scc_pkg::RST_VIDEO_HEIGHT;
    logic [scc_pkg::LIM_REG_W-1:0] sd_limit_set      = scc_pkg::RST_SD_LINE_LIMIT;
    logic [scc_pkg::LIM_REG_W-1:0] hd_limit_set      = scc_pkg::RST_HD_LINE_LIMIT;
    logic [scc_pkg::MS_W-1:0]      min_duration_set  = scc_pkg::RST_MIN_DURATION;
    logic [scc_pkg::MS_W-1:0]      max_duration_set  = scc_pkg::RST_MAX_DURATION;
    logic [scc_pkg::LIM_REG_W-1:0] max_lines_set     = scc_pkg::RST_MAX_LINES;
    logic [scc_pkg::LIM_REG_W-1:0] max_bytes_set     = scc_pkg::RST_MAX_TEXT_BYTES;

    // Cue state as the block should hold it.
    logic [scc_pkg::MS_W-1:0]  last_end_ms    = '0;
    bit                        last_end_known = 1'b0;
    logic [scc_pkg::OUT_W-1:0] errors_logged  = '0;
    logic [scc_pkg::MS_W-1:0]  cue_begin_ms   = '0;
    logic [scc_pkg::MS_W-1:0]  cue_end_ms     = '0;
    logic [scc_pkg::OUT_W-1:0] line_chars     = '0;
    logic [scc_pkg::OUT_W-1:0] widest_line    = '0;
    logic [scc_pkg::OUT_W-1:0] lines_seen     = 16'd1;
    logic [scc_pkg::OUT_W-1:0] bytes_seen     = '0;
    int unsigned               skip_count     = 0;
    bit                        newline_held   = 1'b0;
    bit                        control_found  = 1'b0;
    scc_pkg::tag_state_t       tag_stage      = scc_pkg::TAG_IDLE;
    bit                        tag_found      = 1'b0;

    scc_pkg::result_t pending_reports[$];
    int unsigned mismatches       = 0;
    int unsigned reports_checked  = 0;
    int unsigned requests_sent    = 0;
    int unsigned settings_loaded  = 0;
    int unsigned cycle_count      = 0;
    int unsigned src_idle_pct     = 0;
    int unsigned sink_stall_pct   = 0;

    string tag_words[6] = '{"</i>", "</b>", "</u>", "</span>", "</spa>", "<</"};

    function automatic logic [scc_pkg::OUT_W-1:0] bump(input logic [scc_pkg::OUT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function void clear_text_state();
        line_chars    = '0;
        widest_line   = '0;
        lines_seen    = 16'd1;
        bytes_seen    = '0;
        skip_count    = 0;
        newline_held  = 1'b0;
        control_found = 1'b0;
        tag_stage     = scc_pkg::TAG_IDLE;
        tag_found     = 1'b0;
    endfunction

    // Advance the closing-tag matcher by one byte; any "<" restarts it.
    function void step_tag_matcher(input logic [scc_pkg::BYTE_W-1:0] b);
        scc_pkg::tag_state_t nxt;
        nxt = scc_pkg::TAG_IDLE;
        case (tag_stage)
            scc_pkg::TAG_LT:
                if (b == scc_pkg::CHAR_SLASH) nxt = scc_pkg::TAG_SLASH;
            scc_pkg::TAG_SLASH:
                if (b == scc_pkg::CHAR_S) nxt = scc_pkg::TAG_S;
                else if (b == scc_pkg::CHAR_I || b == scc_pkg::CHAR_B || b == scc_pkg::CHAR_U)
                    nxt = scc_pkg::TAG_LETTER;
            scc_pkg::TAG_S:
                if (b == scc_pkg::CHAR_P) nxt = scc_pkg::TAG_SP;
            scc_pkg::TAG_SP:
                if (b == scc_pkg::CHAR_A) nxt = scc_pkg::TAG_SPA;
            scc_pkg::TAG_SPA:
                if (b == scc_pkg::CHAR_N) nxt = scc_pkg::TAG_SPAN;
            scc_pkg::TAG_SPAN, scc_pkg::TAG_LETTER:
                if (b == scc_pkg::CHAR_GT) tag_found = 1'b1;
            default: ;
        endcase
        if (nxt == scc_pkg::TAG_IDLE && b == scc_pkg::CHAR_LT) nxt = scc_pkg::TAG_LT;
        tag_stage = nxt;
    endfunction

    function void scan_text_byte(input logic [scc_pkg::BYTE_W-1:0] b);
        bytes_seen = bump(bytes_seen);
        if (b < scc_pkg::CTRL_LIMIT && b != scc_pkg::CHAR_NL && b != scc_pkg::CHAR_TAB)
            control_found = 1'b1;
        step_tag_matcher(b);
        // A held newline only opens a new line once another byte shows up.
        if (newline_held)
        begin
            lines_seen   = bump(lines_seen);
            newline_held = 1'b0;
        end
        if (skip_count != 0)
        begin
            // Continuation bytes are swallowed whole, newlines included.
            skip_count--;
        end
        else if (b == scc_pkg::CHAR_NL)
        begin
            if (line_chars > widest_line) widest_line = line_chars;
            line_chars   = '0;
            newline_held = 1'b1;
        end
        else
        begin
            if ((b & scc_pkg::UTF_MASK1) == '0) skip_count = 0;
            else if ((b & scc_pkg::UTF_MASK2) == scc_pkg::UTF_LEAD2) skip_count = 1;
            else if ((b & scc_pkg::UTF_MASK3) == scc_pkg::UTF_LEAD3) skip_count = 2;
            else if ((b & scc_pkg::UTF_MASK4) == scc_pkg::UTF_LEAD4) skip_count = 3;
            else skip_count = 0;
            line_chars = bump(line_chars);
        end
    endfunction

    // Grade the cue that an end request closes and queue its report.
    function void close_cue();
        scc_pkg::result_t          rep;
        logic [scc_pkg::OUT_W-1:0] longest;
        logic [scc_pkg::OUT_W-1:0] limit;
        logic [scc_pkg::MS_W-1:0]  span;
        rep = '0;
        if (last_end_known && cue_begin_ms < last_end_ms)
            rep.flags[scc_pkg::FLAG_OVERLAP] = 1'b1;
        if (cue_end_ms <= cue_begin_ms)
        begin
            rep.flags[scc_pkg::FLAG_ORDER] = 1'b1;
            errors_logged = bump(errors_logged);
        end
        if (cue_end_ms < cue_begin_ms)
        begin
            rep.flags[scc_pkg::FLAG_SHORT] = 1'b1;
        end
        else
        begin
            span = cue_end_ms - cue_begin_ms;
            if (span < min_duration_set) rep.flags[scc_pkg::FLAG_SHORT] = 1'b1;
            if (span > max_duration_set) rep.flags[scc_pkg::FLAG_LONG] = 1'b1;
        end
        longest = (line_chars > widest_line) ? line_chars : widest_line;
        limit = (video_width_set > scc_pkg::HD_WIDTH_MIN
                 || video_height_set > scc_pkg::HD_HEIGHT_MIN)
              ? hd_limit_set : sd_limit_set;
        if (longest > limit) rep.flags[scc_pkg::FLAG_LINE_LONG] = 1'b1;
        if (lines_seen > max_lines_set) rep.flags[scc_pkg::FLAG_LINES] = 1'b1;
        if (control_found) rep.flags[scc_pkg::FLAG_CONTROL] = 1'b1;
        if (bytes_seen == '0) rep.flags[scc_pkg::FLAG_EMPTY] = 1'b1;
        if (bytes_seen > max_bytes_set) rep.flags[scc_pkg::FLAG_VERBOSE] = 1'b1;
        if (tag_found) rep.flags[scc_pkg::FLAG_TAGS] = 1'b1;
        rep.longest_line = longest;
        rep.line_count   = lines_seen;
        rep.error_count  = errors_logged;
        pending_reports.push_back(rep);
        last_end_ms    = cue_end_ms;
        last_end_known = 1'b1;
        clear_text_state();
    endfunction

    function void follow_request(input scc_pkg::cmd_t cmd, input logic [scc_pkg::MS_W-1:0] s, e,
                                 input logic [scc_pkg::BYTE_W-1:0] b);
        case (cmd)
            scc_pkg::CMD_BEGIN:
            begin
                cue_begin_ms = s;
                cue_end_ms   = e;
                clear_text_state();
            end
            scc_pkg::CMD_TEXT:  scan_text_byte(b);
            scc_pkg::CMD_END:   close_cue();
            scc_pkg::CMD_CLEAR: errors_logged = '0;
            default: ;
        endcase
    endfunction

    function void flag_mismatch(input string field, input logic [31:0] want, got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    endfunction

    // Receiver side: take reports, compare them in order, and stall at random.
    always @(posedge clk)
    begin : report_check
        scc_pkg::result_t want;
        if (report_bus.valid && report_bus.ready)
        begin
            if (pending_reports.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: unexpected report, expected none, actual flags %0h count %0h",
                             $time, report_bus.flags, report_bus.line_count);
            end
            else
            begin
                want = pending_reports.pop_front();
                reports_checked++;
                if (report_bus.flags !== want.flags)
                    flag_mismatch("flags", want.flags, report_bus.flags);
                if (report_bus.longest_line !== want.longest_line)
                    flag_mismatch("longest_line", want.longest_line, report_bus.longest_line);
                if (report_bus.line_count !== want.line_count)
                    flag_mismatch("line_count", want.line_count, report_bus.line_count);
                if (report_bus.error_count !== want.error_count)
                    flag_mismatch("error_count", want.error_count, report_bus.error_count);
            end
        end
        report_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: watchdog expired with %0d reports outstanding",
                     $time, pending_reports.size());
            $display("subtitle_cue_checker regression: fail");
            $finish;
        end
    end

    task automatic set_idling(input idle_mode_t mode);
        case (mode)
            IDLE_NONE:
            begin
                src_idle_pct = 0;
                sink_stall_pct = 0;
            end
            IDLE_SENDER:
            begin
                src_idle_pct = 87;
                sink_stall_pct = 0;
            end
            IDLE_RECEIVER:
            begin
                src_idle_pct = 0;
                sink_stall_pct = 87;
            end
            default:
            begin
                src_idle_pct = 13;
                sink_stall_pct = 13;
            end
        endcase
    endtask

    // Send one request and hold it until accepted. Valid stays high on return so
    // back-to-back requests keep it up unless the sender idles; fields the command ignores get noise.
    task automatic send_request(input scc_pkg::cmd_t cmd, input logic [scc_pkg::MS_W-1:0] s, e,
                                input logic [scc_pkg::BYTE_W-1:0] b);
        if (cmd != scc_pkg::CMD_BEGIN)
        begin
            s = $urandom;
            e = $urandom;
        end
        if (cmd != scc_pkg::CMD_TEXT) b = 8'($urandom);
        if ($urandom_range(99) < src_idle_pct)
        begin
            cue_bus.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < src_idle_pct) @(posedge clk);
        end
        cue_bus.valid     <= 1'b1;
        cue_bus.command   <= cmd;
        cue_bus.begin_ms  <= s;
        cue_bus.end_ms    <= e;
        cue_bus.text_byte <= b;
        @(posedge clk);
        while (!cue_bus.ready) @(posedge clk);
        follow_request(cmd, s, e, b);
        requests_sent++;
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++) send_request(scc_pkg::CMD_TEXT, '0, '0, s[k]);
    endtask

    // Drop valid, wait for every report, then let the result path go quiet.
    task automatic settle_outputs();
        cue_bus.valid <= 1'b0;
        @(posedge clk);
        while (pending_reports.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write all eight registers back to back; call only with the cue path idle.
    task automatic load_settings(input setting_kind_t kind);
        logic [scc_pkg::DATA_W-1:0] vals[8];
        foreach (vals[i]) vals[i] = $urandom;
        case (kind)
            SET_ZERO: foreach (vals[i]) vals[i] = '0;
            SET_FULL: foreach (vals[i]) vals[i] = '1;
            default:
            begin
                // Keep junk in the unused upper bits; the block must drop it.
                case ($urandom_range(2))
                    0: vals[scc_pkg::REG_VIDEO_WIDTH][scc_pkg::VDIM_W-1:0] =
                           scc_pkg::HD_WIDTH_MIN;
                    1: vals[scc_pkg::REG_VIDEO_WIDTH][scc_pkg::VDIM_W-1:0] =
                           scc_pkg::HD_WIDTH_MIN + 1'b1;
                    default: ;
                endcase
                case ($urandom_range(2))
                    0: vals[scc_pkg::REG_VIDEO_HEIGHT][scc_pkg::VDIM_W-1:0] =
                           scc_pkg::HD_HEIGHT_MIN;
                    1: vals[scc_pkg::REG_VIDEO_HEIGHT][scc_pkg::VDIM_W-1:0] =
                           scc_pkg::HD_HEIGHT_MIN + 1'b1;
                    default: ;
                endcase
                vals[scc_pkg::REG_SD_LINE_LIMIT][scc_pkg::LIM_REG_W-1:0]  = $urandom_range(30);
                vals[scc_pkg::REG_HD_LINE_LIMIT][scc_pkg::LIM_REG_W-1:0]  = $urandom_range(30);
                vals[scc_pkg::REG_MIN_DURATION]   = $urandom_range(3000);
                vals[scc_pkg::REG_MAX_DURATION]   = $urandom_range(500, 20000);
                vals[scc_pkg::REG_MAX_LINES][scc_pkg::LIM_REG_W-1:0]      = $urandom_range(5);
                vals[scc_pkg::REG_MAX_TEXT_BYTES][scc_pkg::LIM_REG_W-1:0] = $urandom_range(40);
            end
        endcase
        for (int i = 0; i < 8; i++)
        begin
            cfg_bus.valid <= 1'b1;
            cfg_bus.index <= scc_pkg::cfg_reg_t'(i);
            cfg_bus.data  <= vals[i];
            @(posedge clk);
            while (!cfg_bus.ready) @(posedge clk);
            case (scc_pkg::cfg_reg_t'(i))
                scc_pkg::REG_VIDEO_WIDTH:    video_width_set  = vals[i][scc_pkg::VDIM_W-1:0];
                scc_pkg::REG_VIDEO_HEIGHT:   video_height_set = vals[i][scc_pkg::VDIM_W-1:0];
                scc_pkg::REG_SD_LINE_LIMIT:  sd_limit_set     = vals[i][scc_pkg::LIM_REG_W-1:0];
                scc_pkg::REG_HD_LINE_LIMIT:  hd_limit_set     = vals[i][scc_pkg::LIM_REG_W-1:0];
                scc_pkg::REG_MIN_DURATION:   min_duration_set = vals[i][scc_pkg::MS_W-1:0];
                scc_pkg::REG_MAX_DURATION:   max_duration_set = vals[i][scc_pkg::MS_W-1:0];
                scc_pkg::REG_MAX_LINES:      max_lines_set    = vals[i][scc_pkg::LIM_REG_W-1:0];
                scc_pkg::REG_MAX_TEXT_BYTES: max_bytes_set    = vals[i][scc_pkg::LIM_REG_W-1:0];
                default: ;
            endcase
        end
        cfg_bus.valid <= 1'b0;
        settings_loaded++;
    endtask

    // Timing checks under the reset settings: order, overlap, duration edges.
    task automatic test_cue_timing();
        send_request(scc_pkg::CMD_END, '0, '0, '0);     // end straight after reset, zero times
        send_request(scc_pkg::CMD_BEGIN, '0, '1, '0);   // widest possible span
        send_request(scc_pkg::CMD_TEXT, '0, '0, scc_pkg::CHAR_A);
        send_request(scc_pkg::CMD_END, '0, '0, '0);
        send_request(scc_pkg::CMD_BEGIN, 32'd1000, 32'd1249, '0);  // one below short, overlaps
        send_request(scc_pkg::CMD_END, '0, '0, '0);
        send_request(scc_pkg::CMD_BEGIN, '1, '0, '0);   // end before start
        send_request(scc_pkg::CMD_END, '0, '0, '0);
        send_request(scc_pkg::CMD_BEGIN, 32'd20000, 32'd30001, '0);  // one above the long limit
        send_request(scc_pkg::CMD_END, '0, '0, '0);
        send_request(scc_pkg::CMD_CLEAR, '0, '0, '0);
        send_request(scc_pkg::CMD_END, '0, '0, '0);     // end without begin reuses kept times
    endtask

    // Text scanning: control bytes, UTF-8 skipping, bad leads, newlines, tags.
    task automatic test_text_rules();
        logic [scc_pkg::BYTE_W-1:0] mixed[] = '{8'h00, scc_pkg::CHAR_TAB, 8'h1F, 8'h7F,
                                                scc_pkg::CHAR_NL, 8'hC3, scc_pkg::CHAR_NL,
                                                8'hE2, 8'h82, 8'hAC,
                                                8'hF0, 8'h9F, 8'h98, 8'h80,
                                                8'h80, 8'hFF, 8'hF8,
                                                scc_pkg::CHAR_NL, scc_pkg::CHAR_NL};
        send_request(scc_pkg::CMD_BEGIN, 32'd40000, 32'd42000, '0);
        foreach (mixed[i]) send_request(scc_pkg::CMD_TEXT, '0, '0, mixed[i]);
        send_request(scc_pkg::CMD_END, '0, '0, '0);
        // Text with no begin, a restarted tag, and a lead byte cut off by the end.
        send_text("<</span>");
        send_request(scc_pkg::CMD_TEXT, '0, '0, 8'hE2);
        send_request(scc_pkg::CMD_END, '0, '0, '0);
        send_request(scc_pkg::CMD_BEGIN, 32'd50000, 32'd51000, '0);
        send_text("a</b>\n");
        send_request(scc_pkg::CMD_END, '0, '0, '0);
    endtask

    // Grow the line and line-count counters well past the limits, count up errors, then clear them.
    task automatic test_counter_growth();
        send_request(scc_pkg::CMD_BEGIN, 32'd100, 32'd200, '0);
        repeat (GROWTH_RUN) send_request(scc_pkg::CMD_TEXT, '0, '0, scc_pkg::CHAR_A);
        repeat (GROWTH_RUN / 4) send_request(scc_pkg::CMD_TEXT, '0, '0, scc_pkg::CHAR_NL);
        send_request(scc_pkg::CMD_TEXT, '0, '0, scc_pkg::CHAR_S);
        send_request(scc_pkg::CMD_END, '0, '0, '0);
        send_request(scc_pkg::CMD_BEGIN, 32'd7, 32'd7, '0);
        repeat (GROWTH_RUN / 4) send_request(scc_pkg::CMD_END, '0, '0, '0);
        send_request(scc_pkg::CMD_CLEAR, '0, '0, '0);
        send_request(scc_pkg::CMD_END, '0, '0, '0);
    endtask

    // One random cue: mostly well formed, some broken or stray requests.
    task automatic send_random_cue();
        logic [scc_pkg::BYTE_W-1:0] text_q[$];
        logic [scc_pkg::BYTE_W-1:0] lead;
        logic [scc_pkg::MS_W-1:0]   t0;
        logic [scc_pkg::MS_W-1:0]   span;
        int unsigned                pick;
        int unsigned                tail;
        int unsigned                w;
        pick = $urandom_range(99);
        if (pick < 6)
        begin
            send_request(scc_pkg::CMD_CLEAR, '0, '0, '0);
            return;
        end
        if (pick < 12)
        begin
            send_request(scc_pkg::CMD_END, '0, '0, '0);
            return;
        end
        repeat ($urandom_range(12))
        begin
            case ($urandom_range(9))
                0, 1: text_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
                2:    text_q.push_back(scc_pkg::CHAR_NL);
                3:    text_q.push_back(8'($urandom));
                4:    text_q.push_back(8'($urandom_range(8'h1F)));
                5:
                begin
                    // UTF-8 sequence, sometimes cut short or with a newline inside.
                    tail = $urandom_range(1, 3);
                    case (tail)
                        1: lead = scc_pkg::UTF_LEAD2 | 8'($urandom_range(31));
                        2: lead = scc_pkg::UTF_LEAD3 | 8'($urandom_range(15));
                        default: lead = scc_pkg::UTF_LEAD4 | 8'($urandom_range(7));
                    endcase
                    text_q.push_back(lead);
                    if ($urandom_range(3) == 0) tail = $urandom_range(tail);
                    repeat (tail)
                        text_q.push_back(($urandom_range(3) == 0) ? scc_pkg::CHAR_NL
                                         : (scc_pkg::UTF_MASK1 | 8'($urandom_range(63))));
                end
                6:
                begin
                    w = $urandom_range(5);
                    for (int k = 0; k < tag_words[w].len(); k++)
                        text_q.push_back(tag_words[w][k]);
                end
                default: text_q.push_back(8'($urandom_range(8'h61, 8'h7A)));
            endcase
        end
        if (pick >= 18)
        begin
            case ($urandom_range(3))
                0: t0 = $urandom;
                1: t0 = last_end_ms - $urandom_range(50);
                2: t0 = last_end_ms + $urandom_range(50);
                default: t0 = $urandom_range(1) ? '1 : '0;
            endcase
            case ($urandom_range(4))
                0: span = min_duration_set + $urandom_range(4) - 2;
                1: span = max_duration_set + $urandom_range(4) - 2;
                2: span = $urandom;
                3: span = '0 - $urandom_range(1, 20);
                default: span = $urandom_range(100, 5000);
            endcase
            send_request(scc_pkg::CMD_BEGIN, t0, t0 + span, '0);
        end
        foreach (text_q[i]) send_request(scc_pkg::CMD_TEXT, '0, '0, text_q[i]);
        // Abandon some cues without an end; the next begin starts over.
        if (pick < 18 || pick >= 24) send_request(scc_pkg::CMD_END, '0, '0, '0);
    endtask

    // Random streams over every idling pattern and a spread of settings,
    // extremes first.
    task automatic test_random_streams();
        int unsigned goal;
        for (int blk = 0; blk < RANDOM_BLOCKS; blk++)
        begin
            set_idling(idle_mode_t'(blk % 4));
            settle_outputs();
            load_settings(blk == 0 ? SET_ZERO : (blk == 1 ? SET_FULL : SET_MIXED));
            goal = requests_sent + RANDOM_REQUESTS / RANDOM_BLOCKS;
            while (requests_sent < goal) send_random_cue();
        end
    endtask

    initial
    begin
        cue_bus.valid     <= 1'b0;
        cue_bus.command   <= scc_pkg::CMD_BEGIN;
        cue_bus.begin_ms  <= '0;
        cue_bus.end_ms    <= '0;
        cue_bus.text_byte <= '0;
        cfg_bus.valid     <= 1'b0;
        cfg_bus.index     <= scc_pkg::REG_VIDEO_WIDTH;
        cfg_bus.data      <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_idling(IDLE_BOTH);
        test_cue_timing();
        test_text_rules();
        set_idling(IDLE_NONE);
        test_counter_growth();
        test_random_streams();
        settle_outputs();

        $display("Ran %0d requests, checked %0d cue reports under %0d register settings;",
                 requests_sent, reports_checked, settings_loaded);
        $display("all idling patterns, text rules and counter growth were exercised.");
        if (mismatches == 0)
            $display("subtitle_cue_checker regression: pass");
        else
            $display("subtitle_cue_checker regression: fail");
        $finish;
    end

endmodule
